>>> sv/hamming_secded_codec_assert.svh
// ----------------------------------------------------------------------------
// Hamming SECDED codec assertion macros
// Shorthand for the concurrent checks at the end of the codec top level.
// ----------------------------------------------------------------------------
`ifndef HAMMING_SECDED_CODEC_ASSERT_SVH
`define HAMMING_SECDED_CODEC_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define HSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define HSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/hsc_pkg.sv
// ----------------------------------------------------------------------------
// Hamming SECDED codec package
// Shared widths, codes, configuration struct and position tables.
// ----------------------------------------------------------------------------
package hsc_pkg;

    localparam int WORD_W             = 32;
    localparam int POS_W              = 5;
    localparam int NUM_DATA           = 26;
    localparam int CFG_DATA_W         = 5;
    localparam int CFG_INDEX_W        = 2;
    localparam int DATA_BITS_MIN      = 1;
    localparam int DATA_BITS_MAX      = 26;
    localparam int CHECK_BITS_MIN     = 2;
    localparam int MAX_CHECK_BITS_DEF = 5;

    typedef enum logic
    {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_NONE          = 2'd0,
        ST_CORRECTED     = 2'd1,
        ST_UNCORRECTABLE = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        REG_DATA_BITS  = 2'd0,
        REG_CHECK_BITS = 2'd1,
        REG_SECDED     = 2'd2
    } cfg_index_t;

    // Active code geometry, already clamped into the usable ranges.
    typedef struct packed
    {
        logic [POS_W-1:0] k;
        logic [2:0]       r;
        logic [POS_W-1:0] n;
        logic             secded;
    } cfg_t;

    // Codeword position (one-based) of data bit j: the (j+1)-th position that
    // is not a power of two.
    function automatic logic [POS_W-1:0] data_pos(input int j);
        int               cnt;
        logic [POS_W-1:0] res;
        cnt = 0;
        res = '0;
        for (int p = 3; p < WORD_W; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                if (cnt == j)
                begin
                    res = POS_W'(p);
                end
                cnt++;
            end
        end
        return res;
    endfunction

    // Bit p-1 is set when position p has bit b set in its number.
    function automatic logic [WORD_W-1:0] pos_mask(input int b);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int p = 1; p < WORD_W; p++)
        begin
            m[p-1] = ((p >> b) & 1) != 0;
        end
        return m;
    endfunction

endpackage

>>> sv/hsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Hamming SECDED codec configuration registers
// Holds the code geometry, clamps written values and derives the length.
// ----------------------------------------------------------------------------
module hsc_cfg_regs #(
    parameter int MAX_CHECK_BITS = hsc_pkg::MAX_CHECK_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [hsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hsc_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    output hsc_pkg::cfg_t                      cfg
);

    logic [hsc_pkg::POS_W-1:0] data_bits_reg;
    logic [hsc_pkg::POS_W-1:0] data_bits_next;
    logic [2:0]                check_bits_reg;
    logic [2:0]                check_bits_next;
    logic                      secded_reg;
    logic                      secded_next;
    logic [hsc_pkg::POS_W-1:0] k_wr;
    logic [2:0]                r_wr;

    // Values are clamped on the way in, so the datapath sees legal geometry.
    always_comb
    begin
        if (cfg_wr_data < hsc_pkg::POS_W'(hsc_pkg::DATA_BITS_MIN))
        begin
            k_wr = hsc_pkg::POS_W'(hsc_pkg::DATA_BITS_MIN);
        end
        else if (cfg_wr_data > hsc_pkg::POS_W'(hsc_pkg::DATA_BITS_MAX))
        begin
            k_wr = hsc_pkg::POS_W'(hsc_pkg::DATA_BITS_MAX);
        end
        else
        begin
            k_wr = cfg_wr_data;
        end

        if (cfg_wr_data[2:0] < 3'(hsc_pkg::CHECK_BITS_MIN))
        begin
            r_wr = 3'(hsc_pkg::CHECK_BITS_MIN);
        end
        else if (cfg_wr_data[2:0] > 3'(MAX_CHECK_BITS))
        begin
            r_wr = 3'(MAX_CHECK_BITS);
        end
        else
        begin
            r_wr = cfg_wr_data[2:0];
        end
    end

    always_comb
    begin
        data_bits_next  = data_bits_reg;
        check_bits_next = check_bits_reg;
        secded_next     = secded_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                hsc_pkg::REG_DATA_BITS:  data_bits_next  = k_wr;
                hsc_pkg::REG_CHECK_BITS: check_bits_next = r_wr;
                hsc_pkg::REG_SECDED:     secded_next     = cfg_wr_data[0];
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_bits_reg  <= hsc_pkg::POS_W'(hsc_pkg::DATA_BITS_MAX);
            check_bits_reg <= 3'(MAX_CHECK_BITS);
            secded_reg     <= 1'b1;
        end
        else
        begin
            data_bits_reg  <= data_bits_next;
            check_bits_reg <= check_bits_next;
            secded_reg     <= secded_next;
        end
    end

    // At most 26 + 5 = 31 positions, so the sum fits the position width.
    assign cfg.k      = data_bits_reg;
    assign cfg.r      = check_bits_reg;
    assign cfg.n      = data_bits_reg + hsc_pkg::POS_W'(check_bits_reg);
    assign cfg.secded = secded_reg;

endmodule

>>> sv/hsc_datapath.sv
// ----------------------------------------------------------------------------
// Hamming SECDED codec datapath
// Encodes a data word or checks and corrects a codeword in one pass.
// ----------------------------------------------------------------------------
module hsc_datapath #(
    parameter int MAX_CHECK_BITS = hsc_pkg::MAX_CHECK_BITS_DEF
) (
    input  hsc_pkg::cfg_t                     cfg,
    input  logic                              operation,
    input  logic [hsc_pkg::WORD_W-1:0]        word_in,
    output logic [hsc_pkg::WORD_W-1:0]        word_out,
    output logic [hsc_pkg::POS_W-1:0]         error_position,
    output logic [1:0]                        status
);

    localparam int W = hsc_pkg::WORD_W;
    localparam int PW = hsc_pkg::POS_W;

    logic [hsc_pkg::NUM_DATA-1:0] lane_en;
    logic [W-1:0]                 n_mask;
    logic [W-1:0]                 p_mask;
    logic [MAX_CHECK_BITS-1:0]    r_mask;
    logic [W-1:0]                 enc_data;
    logic [PW-1:0]                enc_syn_full;
    logic [MAX_CHECK_BITS-1:0]    enc_syn;
    logic [W-1:0]                 enc_cw;
    logic [W-1:0]                 enc_word;
    logic [W-1:0]                 dec_cw;
    logic [PW-1:0]                dec_syn_full;
    logic [MAX_CHECK_BITS-1:0]    dec_syn;
    logic [PW-1:0]                syn;
    logic                         dec_par;
    logic [W-1:0]                 fixed_cw;
    logic [W-1:0]                 dec_data;
    logic [PW-1:0]                dec_pos;
    hsc_pkg::status_t             dec_status;

    // Lane and position masks that follow from the code geometry.
    always_comb
    begin
        n_mask = (W'(1) << cfg.n) - W'(1);
        p_mask = n_mask | (W'(1) << cfg.n);
        for (int j = 0; j < hsc_pkg::NUM_DATA; j++)
        begin
            lane_en[j] = (PW'(j) < cfg.k) && (hsc_pkg::data_pos(j) <= cfg.n);
        end
        for (int i = 0; i < MAX_CHECK_BITS; i++)
        begin
            r_mask[i] = 3'(i) < cfg.r;
        end
    end

    // Encode: scatter data bits, then fill check positions and, with SECDED on, parity.
    always_comb
    begin
        enc_data = '0;
        for (int j = 0; j < hsc_pkg::NUM_DATA; j++)
        begin
            if (lane_en[j])
            begin
                enc_data[hsc_pkg::data_pos(j) - PW'(1)] = word_in[j];
            end
        end
        for (int b = 0; b < PW; b++)
        begin
            enc_syn_full[b] = ^(enc_data & n_mask & hsc_pkg::pos_mask(b));
        end
        enc_syn = enc_syn_full[MAX_CHECK_BITS-1:0] & r_mask;
        enc_cw  = enc_data;
        for (int i = 0; i < MAX_CHECK_BITS; i++)
        begin
            if (enc_syn[i] && ((W'(1) << i) <= W'(cfg.n)))
            begin
                enc_cw[PW'((1 << i) - 1)] = 1'b1;
            end
        end
        enc_word = enc_cw;
        if (cfg.secded)
        begin
            enc_word[cfg.n] = ^enc_cw;
        end
    end

    // Decode: syndrome and overall parity, then repair or flag.
    always_comb
    begin
        dec_cw = word_in & n_mask;
        for (int b = 0; b < PW; b++)
        begin
            dec_syn_full[b] = ^(dec_cw & hsc_pkg::pos_mask(b));
        end
        dec_syn = dec_syn_full[MAX_CHECK_BITS-1:0] & r_mask;
        syn     = PW'(dec_syn);
        dec_par = ^(word_in & p_mask);

        dec_status = hsc_pkg::ST_NONE;
        dec_pos    = '0;
        fixed_cw   = dec_cw;
        // A syndrome that points past the codeword cannot be repaired.
        priority if (cfg.secded && syn == '0)
        begin
            if (dec_par)
            begin
                dec_status = hsc_pkg::ST_CORRECTED;
                dec_pos    = cfg.n;
            end
        end
        else if (syn == '0)
        begin
            dec_status = hsc_pkg::ST_NONE;
        end
        else if ((cfg.secded && !dec_par) || syn > cfg.n)
        begin
            dec_status = hsc_pkg::ST_UNCORRECTABLE;
        end
        else
        begin
            dec_status = hsc_pkg::ST_CORRECTED;
            dec_pos    = syn - PW'(1);
            fixed_cw   = dec_cw ^ (W'(1) << (syn - PW'(1)));
        end

        dec_data = '0;
        for (int j = 0; j < hsc_pkg::NUM_DATA; j++)
        begin
            if (lane_en[j])
            begin
                dec_data[j] = fixed_cw[hsc_pkg::data_pos(j) - PW'(1)];
            end
        end
    end

    always_comb
    begin
        unique case (hsc_pkg::op_t'(operation))
            hsc_pkg::OP_ENCODE:
            begin
                word_out       = enc_word;
                error_position = '0;
                status         = hsc_pkg::ST_NONE;
            end
            hsc_pkg::OP_DECODE:
            begin
                word_out       = dec_data;
                error_position = dec_pos;
                status         = dec_status;
            end
            default:
            begin
                word_out       = enc_word;
                error_position = '0;
                status         = hsc_pkg::ST_NONE;
            end
        endcase
    end

endmodule

>>> sv/hamming_secded_codec.sv
// ----------------------------------------------------------------------------
// Hamming SECDED codec
// Encodes data words into Hamming codewords with optional overall parity,
// and checks, corrects and unpacks received codewords.
//
//   Channel  Direction  Handshake              Payload
//   in       request    in_valid / in_ready    operation, word_in
//   out      result     out_valid / out_ready  word_out, error_position, status
//   cfg      write      cfg_wr_en              cfg_index, cfg_wr_data
//
// A request is registered at acceptance and its result moves into the output
// register when that register is empty or taken; one request is taken every
// cycle unless the output stalls, with a single pass between the two registers.
// in_ready drops only when both stages are full and out_ready is low.
// rst_n clears both stages and restores 26 data bits, MAX_CHECK_BITS check bits, SECDED on.
// ----------------------------------------------------------------------------
`include "hamming_secded_codec_assert.svh"

module hamming_secded_codec #(
    parameter int MAX_CHECK_BITS = hsc_pkg::MAX_CHECK_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [hsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hsc_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              operation,
    input  logic [hsc_pkg::WORD_W-1:0]        word_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hsc_pkg::WORD_W-1:0]        word_out,
    output logic [hsc_pkg::POS_W-1:0]         error_position,
    output logic [1:0]                        status
);

    hsc_pkg::cfg_t                cfg;
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic                         op_reg;
    logic [hsc_pkg::WORD_W-1:0]   word_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [hsc_pkg::WORD_W-1:0]   word_out_reg;
    logic [hsc_pkg::POS_W-1:0]    error_position_reg;
    logic [1:0]                   status_reg;
    logic [hsc_pkg::WORD_W-1:0]   dp_word;
    logic [hsc_pkg::POS_W-1:0]    dp_pos;
    logic [1:0]                   dp_status;
    logic                         out_adv;
    logic                         in_take;
    logic                         out_load;

    hsc_cfg_regs #(
        .MAX_CHECK_BITS (MAX_CHECK_BITS)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    hsc_datapath #(
        .MAX_CHECK_BITS (MAX_CHECK_BITS)
    ) u_dp (
        .cfg            (cfg),
        .operation      (op_reg),
        .word_in        (word_reg),
        .word_out       (dp_word),
        .error_position (dp_pos),
        .status         (dp_status)
    );

    // The output register moves when empty or taken; stage one follows it.
    assign out_adv  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_adv;
    assign in_take  = in_valid && in_ready;
    assign out_load = out_adv && s1_valid_reg;

    assign s1_valid_next  = in_ready ? in_valid : s1_valid_reg;
    assign out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg   <= operation;
            word_reg <= word_in;
        end
        if (out_load)
        begin
            word_out_reg       <= dp_word;
            error_position_reg <= dp_pos;
            status_reg         <= dp_status;
        end
    end

    assign out_valid      = out_valid_reg;
    assign word_out       = word_out_reg;
    assign error_position = error_position_reg;
    assign status         = status_reg;

    `HSC_ASSERT_NOW(a_full_blocks_input, out_valid_reg && !out_ready && s1_valid_reg, !in_ready, "input taken while both stages are full")
    `HSC_ASSERT_NEXT(a_stage_moves_out, s1_valid_reg && out_adv, out_valid_reg, "registered request did not reach the output register")
    `HSC_ASSERT_NOW(a_pos_only_on_fix, out_valid_reg && status_reg != hsc_pkg::ST_CORRECTED, error_position_reg == '0, "error position set without a correction")

endmodule
